@@ src/glpf_pkg.sv @@
`default_nettype none

package glpf_pkg;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_COLS_W = 6;
    localparam int OUT_ROW_W  = 10;
    localparam int OUT_COL_W  = 5;

    typedef enum logic {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } t_reg_index;

    // One classified pixel as it travels from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [ROW_W-1:0] row;
        logic             r_ge1;
        logic             r_ge2;
        logic             last_row;
        logic             last_col;
        logic             c_ge1;
        logic             c_ge2;
        logic             single_col;
    } t_tag;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DRAIN,
        BK_EOF
    } t_back_state;

endpackage

`default_nettype wire

@@ src/grid_local_peak_finder.sv @@
// Throughput: one pixel per cycle, set by the single compare stage of the back
// end, while the output is not stalled and no final-row scan is running. After
// the last pixel of a frame, the final-row flag scan visits one column per cycle
// while the output is free, and then sends the end-of-frame record.
// Reset is synchronous and active low; the image size returns to 1024 x 32
// (clamped to the parameters) and the row stores keep their contents.
`default_nettype none

module grid_local_peak_finder #(
    parameter int COLS_MAX = 32,
    parameter int ROWS_MAX = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  glpf_pkg::t_reg_index           i_cfg_index,
    input  logic [glpf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [glpf_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [glpf_pkg::OUT_ROW_W-1:0] o_peak_row,
    output logic [glpf_pkg::OUT_COL_W-1:0] o_peak_col,
    output logic                           o_end_of_frame,
    output logic                           o_last_of_run
);

    import glpf_pkg::*;

    localparam int CW       = $clog2(COLS_MAX);
    localparam int RST_ROWS = (ROWS_MAX < 1024) ? ROWS_MAX : 1024;
    localparam int RST_COLS = (COLS_MAX < 32) ? COLS_MAX : 32;
    localparam int QW       = $bits(t_tag) + CW;

    // The image size is kept as the index of the last row and last column,
    // which is what the position counters compare against.
    logic [ROW_W-1:0]      r_last_row, n_last_row;
    logic [CW-1:0]         r_last_col, n_last_col;
    logic [ROW_W-1:0]      cfg_rows;
    logic [CFG_COLS_W-1:0] cfg_cols;
    logic                  cfg_restart;

    always_comb begin
        cfg_rows    = i_cfg_data[ROW_W-1:0];
        cfg_cols    = i_cfg_data[CFG_COLS_W-1:0];
        n_last_row  = r_last_row;
        n_last_col  = r_last_col;
        cfg_restart = i_cfg_we &&
                      (i_cfg_index == REG_IMAGE_ROWS || i_cfg_index == REG_IMAGE_COLS);
        if (i_cfg_we) begin
            // A size of zero acts as one; sizes above the maximum saturate.
            case (i_cfg_index)
                REG_IMAGE_ROWS: begin
                    if (cfg_rows == '0) begin
                        n_last_row = '0;
                    end else if (32'(cfg_rows) > 32'(ROWS_MAX)) begin
                        n_last_row = ROW_W'(ROWS_MAX - 1);
                    end else begin
                        n_last_row = cfg_rows - 1'b1;
                    end
                end
                REG_IMAGE_COLS: begin
                    if (cfg_cols == '0) begin
                        n_last_col = '0;
                    end else if (32'(cfg_cols) > 32'(COLS_MAX)) begin
                        n_last_col = CW'(COLS_MAX - 1);
                    end else begin
                        n_last_col = CW'(cfg_cols - 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= ROW_W'(RST_ROWS - 1);
            r_last_col <= CW'(RST_COLS - 1);
        end else begin
            r_last_row <= n_last_row;
            r_last_col <= n_last_col;
        end
    end

    // The front end tracks the pixel position and classifies each pixel by
    // its place in the image (border, last row, last column). Classified
    // pixels wait in a two-entry queue so that the back end, which stalls on
    // the output and during the final-row scan, never holds up a transfer
    // that the queue can still absorb.
    logic          push, q_full, q_valid, pop;
    t_tag          push_tag, head_tag;
    logic [CW-1:0] push_col, head_col;
    logic [QW-1:0] q_rdata;

    glpf_front #(.COLS_MAX(COLS_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_restart),
        .i_last_row    (r_last_row),
        .i_last_col    (r_last_col),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .i_fifo_full   (q_full),
        .o_push        (push),
        .o_tag         (push_tag),
        .o_col         (push_col)
    );

    glpf_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_tag, push_col}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign head_tag = q_rdata[QW-1:CW];
    assign head_col = q_rdata[CW-1:0];

    // The back end holds the two previous rows in column-indexed stores and
    // decides the pixel above each arriving pixel. Final-row peaks are kept
    // as flags and sent, in column order, once the frame's last pixel is in.
    glpf_back #(.COLS_MAX(COLS_MAX)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_restart),
        .i_last_col     (r_last_col),
        .i_valid        (q_valid),
        .i_tag          (head_tag),
        .i_col          (head_col),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_peak_row     (o_peak_row),
        .o_peak_col     (o_peak_col),
        .o_end_of_frame (o_end_of_frame),
        .o_last_of_run  (o_last_of_run)
    );

    // The end-of-frame record always closes the run of its pixel.
    a_eof_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_last_of_run)
        else $error("end-of-frame record without last_of_run");

    // The end-of-frame record carries no position.
    a_eof_no_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> (o_peak_row == '0 && o_peak_col == '0))
        else $error("end-of-frame record with a nonzero position");

    // The queue never takes a pixel while it is full.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("pixel pushed into a full queue");

endmodule

`default_nettype wire

@@ src/glpf_ram.sv @@
`default_nettype none

module glpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/glpf_fifo.sv @@
`default_nettype none

module glpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ src/glpf_front.sv @@
`default_nettype none

module glpf_front #(
    parameter int COLS_MAX = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [glpf_pkg::ROW_W-1:0]  i_last_row,
    input  logic [$clog2(COLS_MAX)-1:0] i_last_col,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [glpf_pkg::PIX_W-1:0]  i_pixel_value,
    input  logic                        i_fifo_full,
    output logic                        o_push,
    output glpf_pkg::t_tag              o_tag,
    output logic [$clog2(COLS_MAX)-1:0] o_col
);

    import glpf_pkg::*;

    localparam int CW = $clog2(COLS_MAX);

    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic             accept;
    logic             at_last_row;
    logic             at_last_col;

    always_comb begin
        accept      = i_in_valid && !i_fifo_full;
        at_last_row = (r_row == i_last_row);
        at_last_col = (r_col == i_last_col);

        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            // The final pixel of a frame wraps both counters back to zero.
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end

        o_tag.px         = i_pixel_value;
        o_tag.row        = r_row;
        o_tag.r_ge1      = (r_row != '0);
        o_tag.r_ge2      = (r_row > ROW_W'(1));
        o_tag.last_row   = at_last_row;
        o_tag.last_col   = at_last_col;
        o_tag.c_ge1      = (r_col != '0);
        o_tag.c_ge2      = (r_col > CW'(1));
        o_tag.single_col = (i_last_col == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_in_ready = !i_fifo_full;
    assign o_push     = accept;
    assign o_col      = r_col;

endmodule

`default_nettype wire

@@ src/glpf_back.sv @@
`default_nettype none

module glpf_back #(
    parameter int COLS_MAX = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(COLS_MAX)-1:0]    i_last_col,
    input  logic                           i_valid,
    input  glpf_pkg::t_tag                 i_tag,
    input  logic [$clog2(COLS_MAX)-1:0]    i_col,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [glpf_pkg::OUT_ROW_W-1:0] o_peak_row,
    output logic [glpf_pkg::OUT_COL_W-1:0] o_peak_col,
    output logic                           o_end_of_frame,
    output logic                           o_last_of_run
);

    import glpf_pkg::*;

    localparam int CW = $clog2(COLS_MAX);

    function automatic logic f_peak(
        input logic [PIX_W-1:0] self_px,
        input logic             has_up,
        input logic [PIX_W-1:0] up_px,
        input logic             has_left,
        input logic [PIX_W-1:0] left_px,
        input logic             has_right,
        input logic [PIX_W-1:0] right_px,
        input logic             has_down,
        input logic [PIX_W-1:0] down_px
    );
        f_peak = !((has_up    && (self_px < up_px))    ||
                   (has_left  && (self_px < left_px))  ||
                   (has_right && (self_px < right_px)) ||
                   (has_down  && (self_px < down_px)));
    endfunction

    t_back_state      r_state, n_state;
    logic             r_b_valid, n_b_valid;
    t_tag             r_b_tag;
    logic [CW-1:0]    r_b_col;
    logic             r_byp_mid, r_byp_up;
    logic [PIX_W-1:0] r_byp_mid_data, r_byp_up_data;
    logic [PIX_W-1:0] r_self, r_prev_self, r_px1, r_px2;
    logic [COLS_MAX-1:0] r_flags, n_flags;
    logic [CW-1:0]    r_scan, n_scan;
    logic [ROW_W-1:0] r_final_row, n_final_row;

    logic                 r_o_valid, n_o_valid;
    logic [OUT_ROW_W-1:0] r_o_row, n_o_row;
    logic [OUT_COL_W-1:0] r_o_col, n_o_col;
    logic                 r_o_eof, n_o_eof;
    logic                 r_o_last, n_o_last;

    logic [PIX_W-1:0] mid_rdata, up_rdata, mid_val, up_val;
    logic [CW-1:0]    rd_addr_mid;
    logic [CW-1:0]    col_prev;
    logic             out_free, b_done, pop;
    logic             up_peak, lr_prev, lr_cur, frame_end;

    // Row r-1 delay line, read one column ahead so the right neighbor is on hand.
    glpf_ram #(.WIDTH(PIX_W), .DEPTH(COLS_MAX)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (b_done),
        .i_waddr (r_b_col),
        .i_wdata (r_b_tag.px),
        .i_re    (pop),
        .i_raddr (rd_addr_mid),
        .o_rdata (mid_rdata)
    );

    // Row r-2 delay line.
    glpf_ram #(.WIDTH(PIX_W), .DEPTH(COLS_MAX)) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (b_done && r_b_tag.r_ge1),
        .i_waddr (r_b_col),
        .i_wdata (r_self),
        .i_re    (pop),
        .i_raddr (i_col),
        .o_rdata (up_rdata)
    );

    always_comb begin
        out_free    = !r_o_valid || i_out_ready;
        b_done      = r_b_valid && (r_state == BK_RUN) && out_free;
        pop         = i_valid && (r_state == BK_RUN) && (!r_b_valid || b_done);
        rd_addr_mid = i_tag.last_col ? '0 : i_col + 1'b1;
        col_prev    = r_b_col - 1'b1;

        mid_val = r_byp_mid ? r_byp_mid_data : mid_rdata;
        up_val  = r_byp_up  ? r_byp_up_data  : up_rdata;

        up_peak = r_b_tag.r_ge1 &&
                  f_peak(r_self, r_b_tag.r_ge2, up_val, r_b_tag.c_ge1, r_prev_self,
                         !r_b_tag.last_col, mid_val, 1'b1, r_b_tag.px);
        lr_prev = r_b_tag.last_row && r_b_tag.c_ge1 &&
                  f_peak(r_px1, r_b_tag.r_ge1, r_prev_self, r_b_tag.c_ge2, r_px2,
                         1'b1, r_b_tag.px, 1'b0, '0);
        lr_cur  = r_b_tag.last_row && r_b_tag.last_col &&
                  f_peak(r_b_tag.px, r_b_tag.r_ge1, r_self, r_b_tag.c_ge1, r_px1,
                         1'b0, '0, 1'b0, '0);
        frame_end = r_b_tag.last_row && r_b_tag.last_col;

        n_state     = r_state;
        n_scan      = r_scan;
        n_flags     = r_flags;
        n_final_row = r_final_row;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_eof     = r_o_eof;
        n_o_last    = r_o_last;

        n_b_valid = r_b_valid;
        if (b_done) begin
            n_b_valid = 1'b0;
        end
        if (pop) begin
            n_b_valid = 1'b1;
        end

        case (r_state)
            BK_RUN: begin
                if (b_done) begin
                    if (up_peak) begin
                        n_o_valid = 1'b1;
                        n_o_row   = OUT_ROW_W'(r_b_tag.row - 1'b1);
                        n_o_col   = OUT_COL_W'(r_b_col);
                        n_o_eof   = 1'b0;
                        n_o_last  = !frame_end;
                    end
                    if (lr_prev) begin
                        n_flags[col_prev] = 1'b1;
                    end
                    if (lr_cur) begin
                        n_flags[r_b_col] = 1'b1;
                    end
                    if (frame_end) begin
                        n_state     = BK_DRAIN;
                        n_scan      = '0;
                        n_final_row = r_b_tag.row;
                    end
                end
            end
            BK_DRAIN: begin
                if (out_free) begin
                    if (r_flags[r_scan]) begin
                        n_o_valid = 1'b1;
                        n_o_row   = OUT_ROW_W'(r_final_row);
                        n_o_col   = OUT_COL_W'(r_scan);
                        n_o_eof   = 1'b0;
                        n_o_last  = 1'b0;
                    end
                    if (r_scan == i_last_col) begin
                        n_state = BK_EOF;
                    end else begin
                        n_scan = r_scan + 1'b1;
                    end
                end
            end
            BK_EOF: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_row   = '0;
                    n_o_col   = '0;
                    n_o_eof   = 1'b1;
                    n_o_last  = 1'b1;
                    n_flags   = '0;
                    n_state   = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase

        if (i_restart) begin
            n_state   = BK_RUN;
            n_flags   = '0;
            n_b_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_RUN;
            r_b_valid <= 1'b0;
            r_flags   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= n_b_valid;
            r_flags   <= n_flags;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_final_row <= n_final_row;
        r_o_row     <= n_o_row;
        r_o_col     <= n_o_col;
        r_o_eof     <= n_o_eof;
        r_o_last    <= n_o_last;
        if (pop) begin
            // A read that meets the retiring item's write takes the new data.
            r_b_tag        <= i_tag;
            r_b_col        <= i_col;
            r_byp_mid      <= b_done && (r_b_col == rd_addr_mid);
            r_byp_up       <= b_done && r_b_tag.r_ge1 && (r_b_col == i_col);
            r_byp_mid_data <= r_b_tag.px;
            r_byp_up_data  <= r_self;
        end
        if (b_done) begin
            r_self      <= r_b_tag.single_col ? r_b_tag.px : mid_val;
            r_prev_self <= r_self;
            r_px1       <= r_b_tag.px;
            r_px2       <= r_px1;
        end
    end

    assign o_pop          = pop;
    assign o_out_valid    = r_o_valid;
    assign o_peak_row     = r_o_row;
    assign o_peak_col     = r_o_col;
    assign o_end_of_frame = r_o_eof;
    assign o_last_of_run  = r_o_last;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;

    import glpf_pkg::*;

    // Geometry of the instance under test; the block defaults are kept.
    localparam int COLS_MAX = 32;
    localparam int ROWS_MAX = 1024;

    // Pixels of the random part, counted over whole and cut-short frames alike.
    localparam int RANDOM_PIXELS = 390;

    // Quiet time before a size write and at the end. It covers a pixel still in the
    // queue, the compare stage or the output register, and the final-row scan, so
    // this covers anything still moving through the block.
    localparam int QUIET_CYCLES = 48;

    // Hard stop.
    localparam int CYCLE_LIMIT = 200000;

    // Share of cycles, in percent, at which each side holds back.
    localparam int IDLE_PERCENT = 11;

    // Only the first mismatches are printed; every one is counted.
    localparam int PRINT_LIMIT = 100;

    // How the pixel values of a frame are drawn.
    typedef enum int {
        MIX_WIDE,       // any 16-bit value
        MIX_TIES,       // 0 to 3, so that equal neighbors are common
        MIX_EXTREME,    // only 0 and all ones
        MIX_NEAR_TOP    // the three largest values
    } t_pixel_mix;

    // One expected peak record.
    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 eof;
        logic                 run_end;
    } t_peak_rec;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    t_reg_index           i_cfg_index   = REG_IMAGE_ROWS;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [PIX_W-1:0]     i_pixel_value = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUT_ROW_W-1:0] o_peak_row;
    logic [OUT_COL_W-1:0] o_peak_col;
    logic                 o_end_of_frame;
    logic                 o_last_of_run;

    grid_local_peak_finder #(
        .COLS_MAX(COLS_MAX),
        .ROWS_MAX(ROWS_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_peak_row    (o_peak_row),
        .o_peak_col    (o_peak_col),
        .o_end_of_frame(o_end_of_frame),
        .o_last_of_run (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // Pixels waiting to be offered, and the peak records still owed by the block.
    logic [PIX_W-1:0] pixel_backlog[$];
    t_peak_rec        expected_peaks[$];

    int unsigned pixels_queued = 0;
    int unsigned pixels_taken  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    // While set, neither side idles: this gives a stretch at full rate.
    bit steady = 1'b0;

    // Shadow of the detector: image size, the two row stores, the left
    // neighbor of the pixel being decided, the last-row flags and the position
    // of the next pixel in the frame.
    int unsigned      n_rows;
    int unsigned      n_cols;
    logic [PIX_W-1:0] above_row[COLS_MAX];
    logic [PIX_W-1:0] mid_row[COLS_MAX];
    logic [PIX_W-1:0] left_px;
    bit               peak_flags[COLS_MAX];
    int unsigned      cur_row;
    int unsigned      cur_col;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want) begin
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // A size register value of 0 acts as 1, anything above the maximum as the maximum.
    function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
        if (v < 1) begin
            return 1;
        end
        return (v > top) ? top : v;
    endfunction

    function automatic void restart_frame();
        cur_row = 0;
        cur_col = 0;
        left_px = '0;
        foreach (peak_flags[j]) begin
            peak_flags[j] = 1'b0;
        end
    endfunction

    // True when the pixel is not below any neighbor that exists.
    function automatic bit dominates(
        input logic [PIX_W-1:0] ctr,
        input bit has_up,    input logic [PIX_W-1:0] up,
        input bit has_left,  input logic [PIX_W-1:0] left,
        input bit has_right, input logic [PIX_W-1:0] right,
        input bit has_down,  input logic [PIX_W-1:0] down
    );
        if (has_up && ctr < up) return 1'b0;
        if (has_left && ctr < left) return 1'b0;
        if (has_right && ctr < right) return 1'b0;
        if (has_down && ctr < down) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_peak(input int unsigned r, input int unsigned c, input bit eof);
        expected_peaks.push_back('{row: OUT_ROW_W'(r), col: OUT_COL_W'(c),
                                   eof: eof, run_end: 1'b0});
    endfunction

    // Works out the peak records that one accepted pixel causes and advances
    // the shadow position.
    function automatic void classify_pixel(input logic [PIX_W-1:0] px);
        int unsigned      r;
        int unsigned      c;
        int unsigned      queued_before;
        logic [PIX_W-1:0] ctr;
        logic [PIX_W-1:0] nb_left;
        bit               has_right;
        bit               frame_done;

        r = cur_row;
        c = cur_col;
        queued_before = expected_peaks.size();
        frame_done = 1'b0;

        if (r >= n_rows || c >= n_cols) begin
            restart_frame();
            r = 0;
            c = 0;
        end

        // The new pixel is the down neighbor of the one above it, which is
        // decided now. Its left neighbor is the pixel decided just before.
        if (r >= 1) begin
            ctr = mid_row[c];
            has_right = (c + 1) < n_cols;
            if (dominates(ctr, r >= 2, above_row[c], c >= 1, left_px,
                          has_right, has_right ? mid_row[c + 1] : '0, 1'b1, px)) begin
                add_peak(r - 1, c, 1'b0);
            end
            above_row[c] = ctr;
            left_px = ctr;
        end
        mid_row[c] = px;

        // In the last row nothing lies below, so a pixel is settled once its
        // right neighbor has arrived. Its peak waits in a flag until the frame ends.
        if (r == n_rows - 1) begin
            if (c >= 1) begin
                ctr = mid_row[c - 1];
                nb_left = (c >= 2) ? mid_row[c - 2] : '0;
                if (dominates(ctr, r >= 1, above_row[c - 1], c >= 2, nb_left,
                              1'b1, px, 1'b0, '0)) begin
                    peak_flags[c - 1] = 1'b1;
                end
            end
            if (c == n_cols - 1) begin
                nb_left = (c >= 1) ? mid_row[c - 1] : '0;
                if (dominates(px, r >= 1, above_row[c], c >= 1, nb_left,
                              1'b0, '0, 1'b0, '0)) begin
                    peak_flags[c] = 1'b1;
                end
                for (int unsigned j = 0; j < n_cols; j++) begin
                    if (peak_flags[j]) begin
                        add_peak(r, j, 1'b0);
                    end
                end
                add_peak(0, 0, 1'b1);
                restart_frame();
                frame_done = 1'b1;
            end
        end

        if (!frame_done) begin
            c++;
            if (c >= n_cols) begin
                c = 0;
                r++;
            end
            cur_row = r;
            cur_col = c;
        end

        if (expected_peaks.size() > queued_before) begin
            expected_peaks[expected_peaks.size() - 1].run_end = 1'b1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_pixel_mix mix);
        case (mix)
            MIX_TIES: begin
                return PIX_W'($urandom_range(3));
            end
            MIX_EXTREME: begin
                return $urandom_range(1) ? '1 : '0;
            end
            MIX_NEAR_TOP: begin
                return 16'hFFFF - PIX_W'($urandom_range(2));
            end
            default: begin
                return PIX_W'($urandom);
            end
        endcase
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] px);
        pixel_backlog.push_back(px);
        pixels_queued++;
    endtask

    // Returns once every queued pixel has been transferred and every expected
    // record has come back, plus a quiet stretch for pixels that cause none.
    task automatic settle();
        while (pixels_taken != pixels_queued || expected_peaks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // One size register write. Any write aborts the frame in progress, so the
    // shadow restarts its frame too. The block is idle whenever this is called.
    task automatic write_size(input t_reg_index idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_ROWS) begin
            n_rows = fit_size(data, ROWS_MAX);
        end else begin
            n_cols = fit_size(data[CFG_COLS_W-1:0], COLS_MAX);
        end
        restart_frame();
    endtask

    // Sets the size and streams one frame, or a leading part of it when
    // cut_short is set, so that the next write aborts it.
    task automatic run_frame(input logic [CFG_W-1:0] rows_data,
                             input logic [CFG_W-1:0] cols_data,
                             input t_pixel_mix mix, input bit cut_short,
                             output int unsigned sent);
        write_size(REG_IMAGE_ROWS, rows_data);
        write_size(REG_IMAGE_COLS, cols_data);
        sent = n_rows * n_cols;
        if (cut_short && sent > 1) begin
            sent = $urandom_range(sent - 1, 1);
        end
        repeat (sent) queue_pixel(pick_pixel(mix));
        settle();
    endtask

    // Driver: offers the next pixel unless it decides to idle. Once valid is
    // high it holds, with the same pixel, until the transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pixel_backlog.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                i_in_valid    <= 1'b1;
                i_pixel_value <= pixel_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random, except during the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Monitor: each pixel transfer feeds the shadow detector; each result
    // transfer is held against the oldest expected record.
    always @(posedge i_clk) begin : watch_transfers
        t_peak_rec want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                classify_pixel(i_pixel_value);
                pixels_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_peaks.size() == 0) begin
                    flag_error($sformatf("record row %0d col %0d eof %b with none expected",
                                         o_peak_row, o_peak_col, o_end_of_frame));
                end else begin
                    want = expected_peaks.pop_front();
                    check_field("peak_row", o_peak_row, want.row);
                    check_field("peak_col", o_peak_col, want.col);
                    check_field("end_of_frame", o_end_of_frame, want.eof);
                    check_field("last_of_run", o_last_of_run, want.run_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned      random_pixels;
        int unsigned      sent;
        int unsigned      frame_idx;
        int unsigned      pick;
        int unsigned      rows;
        int unsigned      cols;
        logic [CFG_W-1:0] rows_data;
        logic [CFG_W-1:0] cols_data;

        random_pixels = 0;
        frame_idx = 0;

        // Shadow state after reset: full size, empty stores, first pixel next.
        n_rows = ROWS_MAX;
        n_cols = COLS_MAX;
        foreach (above_row[j]) begin
            above_row[j] = '0;
            mid_row[j] = '0;
        end
        restart_frame();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset size, 1024 x 32: a few pixels of a frame that the first
        // write then aborts.
        repeat (10) queue_pixel(pick_pixel(MIX_EXTREME));
        settle();

        // Written as 0, both sizes act as 1. A single pixel is always a peak
        // and is followed at once by the end-of-frame record.
        write_size(REG_IMAGE_ROWS, '0);
        write_size(REG_IMAGE_COLS, '0);
        queue_pixel('0);
        queue_pixel('1);
        settle();

        // A single row, six columns reached through the column mask, many ties.
        run_frame(11'd1, 11'h7C6, MIX_TIES, 1'b0, sent);

        // A single column: no left or right neighbors.
        run_frame(11'd4, 11'd1, MIX_WIDE, 1'b0, sent);

        // A flat 2 x 2 plateau: every pixel is a peak.
        write_size(REG_IMAGE_ROWS, 11'd2);
        write_size(REG_IMAGE_COLS, 11'd2);
        repeat (4) queue_pixel(16'h5A5A);
        settle();

        // The row count written far above the maximum clamps to 1024; the
        // frame is cut short after a few pixels.
        write_size(REG_IMAGE_ROWS, 11'h7FF);
        write_size(REG_IMAGE_COLS, 11'd1);
        repeat (3) queue_pixel(pick_pixel(MIX_WIDE));
        settle();

        // Random frames, mostly small and complete. Wide frames keep few rows
        // so that the pixel budget spreads over many sizes. Now and then the
        // column value carries junk above its six bits or lies above the
        // maximum, the row value is 0, or the frame is aborted part way.
        while (random_pixels < RANDOM_PIXELS) begin
            steady = (frame_idx >= 2 && frame_idx < 7);
            pick = $urandom_range(99);
            if (pick < 60) begin
                cols = $urandom_range(8, 1);
            end else if (pick < 85) begin
                cols = $urandom_range(31, 9);
            end else begin
                cols = COLS_MAX;
            end
            rows = (cols > 12) ? $urandom_range(3, 1) : $urandom_range(8, 1);

            cols_data = CFG_W'(cols);
            if (pick >= 95) begin
                cols_data = CFG_W'($urandom_range(63, 33));
            end else if ($urandom_range(9) == 0) begin
                cols_data[CFG_W-1:CFG_COLS_W] = (CFG_W - CFG_COLS_W)'($urandom_range(31, 1));
            end
            rows_data = CFG_W'(rows);
            if (rows == 1 && $urandom_range(1) == 1) begin
                rows_data = '0;
            end

            run_frame(rows_data, cols_data, t_pixel_mix'($urandom_range(3)),
                      $urandom_range(9) == 0, sent);
            random_pixels += sent;
            frame_idx++;
        end
        steady = 1'b0;

        settle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/glpf_pkg.sv
src/glpf_ram.sv
src/glpf_fifo.sv
src/glpf_front.sv
src/glpf_back.sv
src/grid_local_peak_finder.sv
bench/tb_top.sv
